>>> design/wgb_pkg.sv
// Shared constants and codes for the windowed Goertzel bin unit.
package wgb_pkg;

    // Field widths of the item and result ports
    localparam int SAMPLE_W  = 16;
    localparam int WIN_W     = 16;
    localparam int WIN_IDX_W = 12;
    localparam int BLEN_W    = 13;
    localparam int COEFF_W   = 16;
    localparam int NORM_W    = 16;
    localparam int MAG_W     = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_LENGTH = 2'd0,
        CFG_COEFF        = 2'd1,
        CFG_NORM_SCALE   = 2'd2
    } cfg_idx_t;

    localparam logic [BLEN_W-1:0] BLEN_RST  = 13'd4096;
    localparam logic [COEFF_W-1:0] COEFF_RST = 16'd0;
    localparam logic [NORM_W-1:0] NORM_RST  = 16'd1;

    // Window weight of exactly one in Q1.15
    localparam logic [WIN_W-1:0] WIN_ONE = 16'd32768;

    localparam int DEF_MAX_BLOCK = 4096;

    // Datapath widths
    localparam int ACC_W   = 48;           // recursion accumulators
    localparam int HALF_W  = ACC_W / 2;    // split point for wide multiplies
    localparam int MUL_W   = 26;           // shared multiplier operand width
    localparam int PROD_W  = 2 * MUL_W;    // multiplier product width
    localparam int FULL_W  = 64;           // recombined wide product
    localparam int T_W     = 50;           // rounded coeff product
    localparam int SUM_W   = 51;           // recursion sum before saturation
    localparam int XW_W    = 17;           // windowed sample
    localparam int RAD_W   = 50;           // square root radicand
    localparam int ROOT_W  = RAD_W / 2;    // square root result
    localparam int REM_W   = ROOT_W + 2;   // square root remainder
    localparam int SH_W    = 5;            // readout normalize shift
    localparam int CNT_W   = 5;            // square root step counter
    localparam int RN_W    = ROOT_W + NORM_W;
    localparam int READ_BITS = 23;         // readout operands below 2^23

endpackage

>>> design/windowed_goertzel_bin_unit.sv
// Windowed Goertzel single-bin detector: window memory, recursion and readout.
//
// Items arrive on in_valid/in_ready. op=1 writes one Q1.15 window entry
// (saturated to one, ignored beyond the table). op=0 feeds one audio
// sample: the window entry at the current block position is read from
// the on-chip table, the sample is weighted and the second-order
// recursion is updated through one shared 26x26 multiplier; the unit
// takes no new item until the sample is done. The sample that completes
// a block starts the readout: a normalize loop (right shift by s <= 25),
// the power term through the same multiplier, a bit-serial square root
// and the scaling. The result goes to an output register on
// out_valid/out_ready; the unit takes new items while it waits there,
// and stalls only if a second block completes before the first result
// is taken.
// The user must make configuration writes (cfg_valid/cfg_ready, always
// ready) only while the unit is idle; the unit does not enforce it. Reset
// clears the recursion, the block position and the registers to their
// defaults; the window table is not cleared and must be loaded before use.
module windowed_goertzel_bin_unit
    import wgb_pkg::*;
#(
    parameter int MAX_BLOCK = DEF_MAX_BLOCK
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // item channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        op,
    input  logic signed [SAMPLE_W-1:0]  sample,
    input  logic [WIN_IDX_W-1:0]        window_index,
    input  logic [WIN_W-1:0]            window_value,
    // result channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [MAG_W-1:0]            magnitude,
    // configuration channel
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    localparam int AW = $clog2(MAX_BLOCK);
    localparam int CW = (AW + 1 > BLEN_W) ? AW + 1 : BLEN_W;
    localparam logic [CW-1:0] MAX_LEN = CW'(MAX_BLOCK);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RDW,
        ST_CLO,
        ST_CHI,
        ST_CSUM,
        ST_UPD,
        ST_MAXQ,
        ST_SHIFT,
        ST_MAA,
        ST_MBB,
        ST_MAB,
        ST_WAB,
        ST_ABLO,
        ST_ABHI,
        ST_ABSUM,
        ST_PSUB,
        ST_SQRT,
        ST_SCALE,
        ST_FIN
    } state_t;

    state_t                     state_reg;
    logic [AW-1:0]              pos_reg;
    logic                       out_valid_reg;
    logic [MAG_W-1:0]           magnitude_reg;
    logic [BLEN_W-1:0]          blen_reg;
    logic signed [COEFF_W-1:0]  coeff_reg;
    logic [NORM_W-1:0]          norm_reg;
    logic signed [ACC_W-1:0]    q1_reg;
    logic signed [ACC_W-1:0]    q2_reg;
    logic [SH_W-1:0]            s_reg;
    logic [CNT_W-1:0]           cnt_reg;

    // datapath registers
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [WIN_W-1:0]           win_rd_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [XW_W-1:0]     xw_reg;
    logic signed [PROD_W-1:0]   plo_reg;
    logic signed [T_W-1:0]      t_reg;
    logic [ACC_W-1:0]           big_reg;
    logic [ACC_W-1:0]           p_reg;
    logic signed [ACC_W-1:0]    ab_reg;
    logic [RAD_W-1:0]           rad_reg;
    logic [REM_W-1:0]           rem_reg;
    logic [ROOT_W-1:0]          root_reg;

    // window table
    logic [WIN_W-1:0]           win_mem [MAX_BLOCK];

    logic                       in_acc;
    logic                       win_we;
    logic                       win_re;
    logic [CW-1:0]              idx_ext;
    logic [WIN_W-1:0]           win_wdata;

    logic [CW-1:0]              blen_ext;
    logic [CW-1:0]              len_eff;
    logic [CW-1:0]              pos_inc;
    logic                       blk_done;

    logic signed [MUL_W-1:0]    mul_a;
    logic signed [MUL_W-1:0]    mul_b;
    logic                       mul_en;

    logic signed [PROD_W-1:0]   xw_sum;
    logic signed [FULL_W-1:0]   full_sum;
    logic signed [SUM_W-1:0]    acc_sum;
    logic signed [ACC_W-1:0]    q0;
    logic [ACC_W-1:0]           abs1;
    logic [ACC_W-1:0]           abs2;
    logic signed [RAD_W+1:0]    p_diff;
    logic [REM_W+1:0]           sq_trial;
    logic [REM_W+1:0]           sq_test;
    logic                       sq_take;
    logic [RN_W+ROOT_W-1:0]     rn_shift;
    logic [RN_W+ROOT_W-17:0]    scaled;
    logic [MAG_W-1:0]           mag_sat;
    logic                       out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign magnitude = magnitude_reg;
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // window write and position read
    assign idx_ext   = CW'(window_index);
    assign win_we    = in_acc && op && (idx_ext < MAX_LEN);
    assign win_re    = in_acc && !op;
    assign win_wdata = (window_value > WIN_ONE) ? WIN_ONE : window_value;

    always_ff @(posedge clk)
    begin
        if (win_we)
        begin
            win_mem[idx_ext[AW-1:0]] <= win_wdata;
        end
        if (win_re)
        begin
            win_rd_reg <= win_mem[pos_reg];
        end
    end

    // effective block length and end-of-block test
    assign blen_ext = CW'(blen_reg);
    always_comb
    begin
        if (blen_ext == '0)
            len_eff = CW'(1);
        else if (blen_ext > MAX_LEN)
            len_eff = MAX_LEN;
        else
            len_eff = blen_ext;
    end
    assign pos_inc  = CW'(pos_reg) + CW'(1);
    assign blk_done = (pos_inc >= len_eff);

    // shared multiplier operand select
    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (state_reg)
            ST_RDW:
            begin
                mul_a = MUL_W'(sample_reg);
                mul_b = $signed({{(MUL_W-WIN_W){1'b0}}, win_rd_reg});
            end
            ST_CLO:
            begin
                mul_a = MUL_W'(coeff_reg);
                mul_b = $signed({{(MUL_W-HALF_W){1'b0}}, q1_reg[HALF_W-1:0]});
            end
            ST_CHI:
            begin
                mul_a = MUL_W'(coeff_reg);
                mul_b = MUL_W'($signed(q1_reg[ACC_W-1:HALF_W]));
            end
            ST_MAA:
            begin
                mul_a = MUL_W'($signed(q1_reg[HALF_W-1:0]));
                mul_b = MUL_W'($signed(q1_reg[HALF_W-1:0]));
            end
            ST_MBB:
            begin
                mul_a = MUL_W'($signed(q2_reg[HALF_W-1:0]));
                mul_b = MUL_W'($signed(q2_reg[HALF_W-1:0]));
            end
            ST_MAB:
            begin
                mul_a = MUL_W'($signed(q1_reg[HALF_W-1:0]));
                mul_b = MUL_W'($signed(q2_reg[HALF_W-1:0]));
            end
            ST_ABLO:
            begin
                mul_a = MUL_W'(coeff_reg);
                mul_b = $signed({{(MUL_W-HALF_W){1'b0}}, ab_reg[HALF_W-1:0]});
            end
            ST_ABHI:
            begin
                mul_a = MUL_W'(coeff_reg);
                mul_b = MUL_W'($signed(ab_reg[ACC_W-1:HALF_W]));
            end
            ST_SCALE:
            begin
                mul_a = $signed({{(MUL_W-ROOT_W){1'b0}}, root_reg});
                mul_b = $signed({{(MUL_W-NORM_W){1'b0}}, norm_reg});
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // rounded windowed sample: (x*w + 2^14) >> 15
    assign xw_sum = prod_reg + PROD_W'(16384);

    // recombine hi/lo partial products, round by 2^13 before the shift
    assign full_sum = (FULL_W'(prod_reg) <<< HALF_W) + FULL_W'(plo_reg)
                      + FULL_W'(8192);

    // recursion sum and 48-bit saturation
    assign acc_sum = SUM_W'(t_reg) - SUM_W'(q2_reg) + SUM_W'(xw_reg);
    always_comb
    begin
        if (!acc_sum[SUM_W-1] && (acc_sum[SUM_W-2:ACC_W-1] != '0))
            q0 = {1'b0, {(ACC_W-1){1'b1}}};
        else if (acc_sum[SUM_W-1] && (acc_sum[SUM_W-2:ACC_W-1] != '1))
            q0 = {1'b1, {(ACC_W-1){1'b0}}};
        else
            q0 = acc_sum[ACC_W-1:0];
    end

    // magnitudes for the normalize search
    assign abs1 = q1_reg[ACC_W-1] ? ACC_W'(-q1_reg) : ACC_W'(q1_reg);
    assign abs2 = q2_reg[ACC_W-1] ? ACC_W'(-q2_reg) : ACC_W'(q2_reg);

    // power term minus rounded cross term
    assign p_diff = $signed({{(RAD_W+2-ACC_W){1'b0}}, p_reg}) - (RAD_W+2)'(t_reg);

    // one root bit per step
    assign sq_trial = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
    assign sq_test  = {2'b00, root_reg, 2'b01};
    assign sq_take  = (sq_trial >= sq_test);

    // scale by norm_scale, undo the normalize shift, drop 16 fraction bits
    assign rn_shift = {{ROOT_W{1'b0}}, prod_reg[RN_W-1:0]} << s_reg;
    assign scaled   = rn_shift[RN_W+ROOT_W-1:16];
    assign mag_sat  = (scaled[RN_W+ROOT_W-17:MAG_W] != '0) ? {MAG_W{1'b1}}
                                                          : scaled[MAG_W-1:0];

    // sequencer, recursion state, configuration and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            blen_reg      <= BLEN_RST;
            coeff_reg     <= COEFF_RST;
            norm_reg      <= NORM_RST;
            q1_reg        <= '0;
            q2_reg        <= '0;
            s_reg         <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_BLOCK_LENGTH: blen_reg  <= cfg_data[BLEN_W-1:0];
                    CFG_COEFF:        coeff_reg <= $signed(cfg_data[COEFF_W-1:0]);
                    CFG_NORM_SCALE:   norm_reg  <= cfg_data[NORM_W-1:0];
                    default:          ;
                endcase
            end

            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && !op)
                        state_reg <= ST_RDW;
                end
                ST_RDW:  state_reg <= ST_CLO;
                ST_CLO:  state_reg <= ST_CHI;
                ST_CHI:  state_reg <= ST_CSUM;
                ST_CSUM: state_reg <= ST_UPD;
                ST_UPD:
                begin
                    q2_reg <= q1_reg;
                    q1_reg <= q0;
                    if (blk_done)
                    begin
                        pos_reg   <= '0;
                        state_reg <= ST_MAXQ;
                    end
                    else
                    begin
                        pos_reg   <= pos_inc[AW-1:0];
                        state_reg <= ST_IDLE;
                    end
                end
                ST_MAXQ:
                begin
                    s_reg     <= '0;
                    state_reg <= ST_SHIFT;
                end
                ST_SHIFT:
                begin
                    // shift both accumulators in place until they fit 24 bits
                    if (big_reg[ACC_W-1:READ_BITS] != '0)
                    begin
                        q1_reg <= q1_reg >>> 1;
                        q2_reg <= q2_reg >>> 1;
                        s_reg  <= s_reg + SH_W'(1);
                    end
                    else
                    begin
                        state_reg <= ST_MAA;
                    end
                end
                ST_MAA:   state_reg <= ST_MBB;
                ST_MBB:   state_reg <= ST_MAB;
                ST_MAB:   state_reg <= ST_WAB;
                ST_WAB:   state_reg <= ST_ABLO;
                ST_ABLO:  state_reg <= ST_ABHI;
                ST_ABHI:  state_reg <= ST_ABSUM;
                ST_ABSUM: state_reg <= ST_PSUB;
                ST_PSUB:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_SQRT;
                end
                ST_SQRT:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(ROOT_W - 1))
                        state_reg <= ST_SCALE;
                end
                ST_SCALE: state_reg <= ST_FIN;
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        q1_reg        <= '0;
                        q2_reg        <= '0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
            sample_reg <= sample;

        if (mul_en)
            prod_reg <= mul_a * mul_b;

        case (state_reg)
            ST_CLO:   xw_reg  <= xw_sum[XW_W+14:15];
            ST_CHI:   plo_reg <= prod_reg;
            ST_CSUM:  t_reg   <= full_sum[FULL_W-1:14];
            ST_MAXQ:  big_reg <= (abs2 > abs1) ? abs2 : abs1;
            ST_SHIFT:
            begin
                if (big_reg[ACC_W-1:READ_BITS] != '0)
                    big_reg <= big_reg >> 1;
            end
            ST_MBB:   p_reg   <= prod_reg[ACC_W-1:0];
            ST_MAB:   p_reg   <= p_reg + prod_reg[ACC_W-1:0];
            ST_WAB:   ab_reg  <= prod_reg[ACC_W-1:0];
            ST_ABHI:  plo_reg <= prod_reg;
            ST_ABSUM: t_reg   <= full_sum[FULL_W-1:14];
            ST_PSUB:
            begin
                rad_reg  <= p_diff[RAD_W+1] ? '0 : p_diff[RAD_W-1:0];
                rem_reg  <= '0;
                root_reg <= '0;
            end
            ST_SQRT:
            begin
                rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
                if (sq_take)
                begin
                    rem_reg  <= REM_W'(sq_trial - sq_test);
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= sq_trial[REM_W-1:0];
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
            end
            ST_FIN:
            begin
                if (out_free)
                    magnitude_reg <= mag_sat;
            end
            default: ;
        endcase
    end

endmodule

>>> bench/goertzel_tb_pkg.sv
`timescale 1ns / 1ps
// Item operation codes shared by the Goertzel bench checker and top.
package goertzel_tb_pkg;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_WINDOW = 1'b1;

endpackage

>>> bench/goertzel_bin_checker.sv
`timescale 1ns / 1ps
// Checker for the Goertzel bin unit: tracks the recursion and scores each magnitude.
module goertzel_bin_checker
    import wgb_pkg::*;
    import goertzel_tb_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic                        op,
    input  logic signed [SAMPLE_W-1:0]  sample,
    input  logic [WIN_IDX_W-1:0]        window_index,
    input  logic [WIN_W-1:0]            window_value,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [MAG_W-1:0]            magnitude,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    output int                          fail_count,
    output int                          pending
);

    localparam int TABLE_DEPTH  = DEF_MAX_BLOCK;
    localparam int REPORT_LIMIT = 10;
    localparam longint ACC_MAX  = (64'sd1 <<< 47) - 64'sd1;
    localparam longint ACC_MIN  = -(64'sd1 <<< 47);
    localparam longint unsigned READ_LIMIT = 64'd1 << READ_BITS;

    // Shadow of the unit's state and registers
    logic [WIN_W-1:0]           win_mem [TABLE_DEPTH];
    longint                     q1;
    longint                     q2;
    int unsigned                pos;
    logic [BLEN_W-1:0]          blen;
    logic signed [COEFF_W-1:0]  k2cos;
    logic [NORM_W-1:0]          nscale;
    logic [MAG_W-1:0]           expected_mags [$];
    int                         errors;

    initial
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
            win_mem[i] = '0;
    end

    function automatic longint sat_acc(longint v);
        if (v > ACC_MAX)
            return ACC_MAX;
        if (v < ACC_MIN)
            return ACC_MIN;
        return v;
    endfunction

    // Bitwise integer square root, floor
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        longint unsigned rem;
        root  = 0;
        rem   = v;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe >>= 2;
        while (probe != 0)
        begin
            if (rem >= root + probe)
            begin
                rem  -= root + probe;
                root  = (root >> 1) + probe;
            end
            else
                root >>= 1;
            probe >>= 2;
        end
        return root;
    endfunction

    // Normalize, form the bin power, take the root and apply the scale
    function automatic logic [MAG_W-1:0] block_magnitude(longint acc1, longint acc2,
                                                         longint k, longint unsigned scale);
        longint unsigned big;
        longint unsigned other;
        int              s;
        longint          a;
        longint          b;
        longint          p;
        longint unsigned m;
        longint unsigned scaled;
        big   = (acc1 < 0) ? -acc1 : acc1;
        other = (acc2 < 0) ? -acc2 : acc2;
        if (other > big)
            big = other;
        s = 0;
        while ((big >> s) >= READ_LIMIT)
            s++;
        a = acc1 >>> s;
        b = acc2 >>> s;
        p = a * a + b * b - ((a * b * k + 64'sd8192) >>> 14);
        if (p < 0)
            p = 0;
        m = int_sqrt(p) << s;
        scaled = (m >> 16) * scale + (((m & 64'hFFFF) * scale) >> 16);
        if (scaled > 64'hFFFF_FFFF)
            scaled = 64'hFFFF_FFFF;
        return scaled[MAG_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        longint          x;
        longint          wt;
        longint          k;
        longint          xw;
        longint          q0;
        int unsigned     len;
        logic [WIN_W-1:0] wv;
        logic [MAG_W-1:0] want;
        if (!rst_n)
        begin
            q1     = 0;
            q2     = 0;
            pos    = 0;
            blen   = BLEN_RST;
            k2cos  = COEFF_RST;
            nscale = NORM_RST;
            expected_mags.delete();
            errors = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            // result side first, so a result never matches an item taken at the same edge
            if (out_valid && out_ready)
            begin
                if (expected_mags.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("%0t: unexpected magnitude %0d, nothing pending",
                                 $realtime, magnitude);
                end
                else
                begin
                    want = expected_mags.pop_front();
                    if (magnitude !== want)
                    begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                            $display("%0t: magnitude expected %0d, got %0d",
                                     $realtime, want, magnitude);
                    end
                end
            end

            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_BLOCK_LENGTH: blen   = cfg_data[BLEN_W-1:0];
                    CFG_COEFF:        k2cos  = cfg_data;
                    CFG_NORM_SCALE:   nscale = cfg_data;
                    default:          ;
                endcase
            end

            // items: window load or one step of the recursion
            if (in_valid && in_ready)
            begin
                if (op == OP_WINDOW)
                begin
                    wv = (window_value > WIN_ONE) ? WIN_ONE : window_value;
                    if (window_index < TABLE_DEPTH)
                        win_mem[window_index] = wv;
                end
                else
                begin
                    x  = sample;
                    wt = win_mem[pos % TABLE_DEPTH];
                    k  = k2cos;
                    xw = (x * wt + 64'sd16384) >>> 15;
                    q0 = sat_acc(((k * q1 + 64'sd8192) >>> 14) - q2 + xw);
                    q2 = q1;
                    q1 = q0;
                    pos++;
                    len = blen;
                    if (len < 1)
                        len = 1;
                    if (len > TABLE_DEPTH)
                        len = TABLE_DEPTH;
                    if (pos >= len)
                    begin
                        expected_mags.push_back(block_magnitude(q1, q2, k, nscale));
                        q1  = 0;
                        q2  = 0;
                        pos = 0;
                    end
                end
            end

            fail_count <= errors;
            pending    <= expected_mags.size();
        end
    end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Top of the Goertzel bin bench: clock, reset, stimulus phases and verdict.
module tb_top;
    import wgb_pkg::*;
    import goertzel_tb_pkg::*;

    localparam int HOLD_CYCLES  = 96;      // covers one sample plus the longest readout
    localparam int TABLE_DEPTH  = DEF_MAX_BLOCK;
    localparam int RANDOM_ITEMS = 1150;
    localparam int PHASES       = 4;
    localparam int TIMEOUT_NS   = 5_000_000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;   // no register behind it

    // idle percentages per phase: none, sender, receiver, both
    localparam int SEND_IDLE_PCT [PHASES] = '{0, 45, 0, 25};
    localparam int STALL_PCT     [PHASES] = '{0, 0, 45, 25};

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic                        op = OP_SAMPLE;
    logic signed [SAMPLE_W-1:0]  sample = '0;
    logic [WIN_IDX_W-1:0]        window_index = '0;
    logic [WIN_W-1:0]            window_value = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic [MAG_W-1:0]            magnitude;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [CFG_DATA_W-1:0]       cfg_data = '0;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int mismatches;
    int outstanding;

    windowed_goertzel_bin_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .sample       (sample),
        .window_index (window_index),
        .window_value (window_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .magnitude    (magnitude),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    goertzel_bin_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .sample       (sample),
        .window_index (window_index),
        .window_value (window_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .magnitude    (magnitude),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (mismatches),
        .pending      (outstanding)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result receiver, stalls at the phase's rate
    always @(posedge clk)
        out_ready <= ($urandom_range(99, 0) >= stall_pct);

    // One item; valid stays high afterwards so back-to-back items need no gap
    task automatic push_item(logic op_v, logic [SAMPLE_W-1:0] smp,
                             logic [WIN_IDX_W-1:0] idx, logic [WIN_W-1:0] wval);
        cfg_valid <= 1'b0;
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        op           <= op_v;
        sample       <= smp;
        window_index <= idx;
        window_value <= wval;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic push_sample(logic [SAMPLE_W-1:0] smp);
        push_item(OP_SAMPLE, smp, WIN_IDX_W'($urandom), WIN_W'($urandom));
    endtask

    task automatic push_window(logic [WIN_IDX_W-1:0] idx, logic [WIN_W-1:0] wval);
        push_item(OP_WINDOW, SAMPLE_W'($urandom), idx, wval);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic load_settings(logic [CFG_DATA_W-1:0] blen_v, logic [CFG_DATA_W-1:0] coeff_v,
                                 logic [CFG_DATA_W-1:0] norm_v);
        write_reg(CFG_BLOCK_LENGTH, blen_v);
        write_reg(CFG_COEFF, coeff_v);
        write_reg(CFG_NORM_SCALE, norm_v);
    endtask

    // Drain: stop sending, wait out every result, then let the readout finish
    task automatic settle();
        in_valid  <= 1'b0;
        cfg_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (HOLD_CYCLES) @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(19, 0))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // mostly legal weights, some above one to hit the clamp
    function automatic logic [WIN_W-1:0] pick_weight();
        case ($urandom_range(9, 0))
            0:       return WIN_ONE;
            1, 2, 3: return WIN_W'($urandom);
            default: return WIN_W'($urandom_range(32768, 0));
        endcase
    endfunction

    task automatic random_settings();
        logic [CFG_DATA_W-1:0] v;
        if ($urandom_range(9, 0) < 7)
        begin
            case ($urandom_range(19, 0))
                0:       v = 16'd0;
                1:       v = 16'd4096;
                2:       v = 16'd8191;
                3, 4:    v = CFG_DATA_W'($urandom_range(64, 17));
                default: v = CFG_DATA_W'($urandom_range(16, 1));
            endcase
            write_reg(CFG_BLOCK_LENGTH, v);
        end
        if ($urandom_range(9, 0) < 6)
        begin
            case ($urandom_range(9, 0))
                0:       v = 16'h8000;
                1:       v = 16'h7FFF;
                2:       v = 16'h4000;
                default: v = CFG_DATA_W'($urandom);
            endcase
            write_reg(CFG_COEFF, v);
        end
        if ($urandom_range(9, 0) < 5)
        begin
            case ($urandom_range(9, 0))
                0:       v = 16'd0;
                1:       v = 16'hFFFF;
                2:       v = 16'd1;
                default: v = CFG_DATA_W'($urandom);
            endcase
            write_reg(CFG_NORM_SCALE, v);
        end
    endtask

    // Samples with some window rewrites, biased toward the low table entries
    task automatic random_segment(int n);
        logic [WIN_IDX_W-1:0] idx;
        repeat (n)
        begin
            if ($urandom_range(99, 0) < 15)
            begin
                if ($urandom_range(9, 0) < 6)
                    idx = WIN_IDX_W'($urandom_range(63, 0));
                else
                    idx = WIN_IDX_W'($urandom);
                push_window(idx, pick_weight());
            end
            else
                push_sample(pick_sample());
        end
    endtask

    initial
    begin
        int done;
        int n;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole window table so no sample ever reads an empty entry
        for (int i = 0; i < TABLE_DEPTH; i++)
            push_window(WIN_IDX_W'(i), pick_weight());

        // one-sample blocks at full scale
        settle();
        load_settings(16'd1, 16'h7FFF, 16'hFFFF);
        push_sample(16'h7FFF);
        push_sample(16'h8000);

        // zero length behaves as one
        settle();
        write_reg(CFG_BLOCK_LENGTH, 16'd0);
        push_sample(16'h0000);
        push_sample(16'hFFFF);

        // window writes inside a block do not disturb the recursion
        settle();
        load_settings(16'd4, 16'h8000, 16'd0);
        push_sample(16'h8000);
        push_window(12'd4095, 16'hFFFF);
        push_window(12'd0, 16'd0);
        push_sample(16'h7FFF);
        push_window(12'd1, WIN_ONE);
        push_sample(16'd1);
        push_sample(16'hFFFE);

        // oversize length clamps, then lowering it mid-block closes the block
        settle();
        load_settings(16'd8191, 16'd0, 16'd1);
        push_sample(16'h1234);
        push_sample(16'h8001);
        push_sample(16'h7FFE);
        settle();
        write_reg(CFG_BLOCK_LENGTH, 16'hE002);
        write_reg(CFG_SPARE, 16'hFFFF);
        push_sample(16'd12345);

        // one full-length block near resonance to push the output clamp
        settle();
        load_settings(16'd4096, 16'h7FFF, 16'hFFFF);
        repeat (TABLE_DEPTH)
            push_sample(SAMPLE_W'(32767 - $urandom_range(255, 0)));

        // random traffic under each idling pattern
        for (int ph = 0; ph < PHASES; ph++)
        begin
            done = 0;
            while (done < RANDOM_ITEMS / PHASES)
            begin
                settle();
                send_idle_pct = SEND_IDLE_PCT[ph];
                stall_pct     = STALL_PCT[ph];
                random_settings();
                n = $urandom_range(60, 20);
                random_segment(n);
                done += n;
            end
        end

        settle();
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> windowed_goertzel_bin_unit.f
design/wgb_pkg.sv
design/windowed_goertzel_bin_unit.sv
bench/goertzel_tb_pkg.sv
bench/goertzel_bin_checker.sv
bench/tb_top.sv
